// ===== sv/rwl_pkg.sv =====
// Shared types, constants and helpers of the reader-writer lock arbiter.
package rwl_pkg;

  localparam int QueueDepth = 16;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int OpW      = 2;
  localparam int ReqW     = 4;
  localparam int EventW   = 3;
  localparam int ReadersW = 5;
  localparam int WaitW    = 5;

  localparam logic [ReadersW-1:0] ReaderCap = '1;

  typedef enum logic [OpW-1:0] {
    OpReadLock    = 2'd0,
    OpReadUnlock  = 2'd1,
    OpWriteLock   = 2'd2,
    OpWriteUnlock = 2'd3
  } opcode_e;

  typedef enum logic [EventW-1:0] {
    EvGranted    = 3'd0,
    EvQueued     = 3'd1,
    EvGrantedQ   = 3'd2,
    EvReleased   = 3'd3,
    EvFull       = 3'd4,
    EvBadRelease = 3'd5
  } event_e;

  typedef struct packed {
    logic [ReqW-1:0] who;
    logic            is_write;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] ptr);
    logic [QPtrW-1:0] nxt;
    if (ptr == QPtrW'(QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + QPtrW'(1);
    end
    return nxt;
  endfunction

endpackage

// ===== sv/fifo_reader_writer_lock_arbiter.sv =====
// FIFO-fair reader-writer lock arbiter. A lock request or an unlock that wakes
// nobody produces one word. An unlock that wakes the queue produces the release
// word first, then reads the queue head from the wait-queue memory; a writer at
// the head is granted once that read data arrives, while a run of readers is
// granted one per cycle after it while the output does not stall. The single
// read port of the queue memory and the one-word output register set this
// pacing; a stall on the output holds the sequence in place. No new request is
// taken until every word of the current one has been loaded into the output.
module fifo_reader_writer_lock_arbiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rwl_pkg::OpW-1:0]      opcode_i,
  input  logic [rwl_pkg::ReqW-1:0]     requester_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rwl_pkg::ReqW-1:0]     target_o,
  output logic [rwl_pkg::EventW-1:0]   event_res_o,
  output logic                         grant_is_write_o,
  output logic                         last_o,
  output logic [rwl_pkg::ReadersW-1:0] readers_now_o,
  output logic                         writer_now_o,
  output logic [rwl_pkg::WaitW-1:0]    waiting_now_o
);

  typedef enum logic [1:0] {
    StIdle,
    StHead,
    StNext
  } state_e;

  state_e state_q, state_d;

  logic [rwl_pkg::ReadersW-1:0] readers_q, readers_d;
  logic                         writer_q, writer_d;
  logic [rwl_pkg::QPtrW-1:0]    head_q, head_d;
  logic [rwl_pkg::QPtrW-1:0]    tail_q, tail_d;
  logic [rwl_pkg::QCntW-1:0]    count_q, count_d;
  rwl_pkg::entry_t              cur_q, cur_d;

  logic                         out_valid_q, out_valid_d;
  logic [rwl_pkg::ReqW-1:0]     target_q, target_d;
  logic [rwl_pkg::EventW-1:0]   event_q, event_d;
  logic                         wr_q, wr_d;
  logic                         last_q, last_d;
  logic [rwl_pkg::ReadersW-1:0] rnow_q, rnow_d;
  logic                         wnow_q, wnow_d;
  logic [rwl_pkg::WaitW-1:0]    qnow_q, qnow_d;

  logic                      out_free;
  logic                      emit;
  logic                      is_wr;
  logic                      lock_now;
  logic                      more;
  logic [rwl_pkg::ReqW-1:0]  e_who;
  rwl_pkg::event_e           e_ev;
  logic                      e_wr;
  logic                      e_last;
  logic                      ram_we;
  rwl_pkg::entry_t           ram_wdata;
  rwl_pkg::entry_t           rd_entry;
  logic [rwl_pkg::EntryW-1:0] ram_rdata;
  logic [rwl_pkg::QPtrW-1:0] ram_raddr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign rd_entry   = rwl_pkg::entry_t'(ram_rdata);

  always_comb begin
    state_d   = state_q;
    readers_d = readers_q;
    writer_d  = writer_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    cur_d     = cur_q;
    emit      = 1'b0;
    is_wr     = 1'b0;
    lock_now  = 1'b0;
    more      = 1'b0;
    e_who     = requester_i;
    e_ev      = rwl_pkg::EvGranted;
    e_wr      = 1'b0;
    e_last    = 1'b1;
    ram_we    = 1'b0;
    ram_wdata = '{who: requester_i, is_write: opcode_i == rwl_pkg::OpWriteLock};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i && out_free) begin
          emit = 1'b1;
          unique case (rwl_pkg::opcode_e'(opcode_i))
            rwl_pkg::OpReadLock, rwl_pkg::OpWriteLock: begin
              is_wr    = (opcode_i == rwl_pkg::OpWriteLock);
              e_wr     = is_wr;
              lock_now = !writer_q && (count_q == '0) &&
                         (!is_wr || (readers_q == '0));
              if (lock_now) begin
                if (is_wr) begin
                  writer_d = 1'b1;
                  e_ev     = rwl_pkg::EvGranted;
                end else if (readers_q == rwl_pkg::ReaderCap) begin
                  e_ev = rwl_pkg::EvFull;
                end else begin
                  readers_d = readers_q + rwl_pkg::ReadersW'(1);
                  e_ev      = rwl_pkg::EvGranted;
                end
              end else if (count_q == rwl_pkg::QCntW'(rwl_pkg::QueueDepth)) begin
                e_ev = rwl_pkg::EvFull;
              end else begin
                ram_we  = 1'b1;
                tail_d  = rwl_pkg::ptr_inc(tail_q);
                count_d = count_q + rwl_pkg::QCntW'(1);
                e_ev    = rwl_pkg::EvQueued;
              end
            end
            rwl_pkg::OpReadUnlock: begin
              e_wr = 1'b0;
              if (readers_q == '0) begin
                e_ev = rwl_pkg::EvBadRelease;
              end else begin
                readers_d = readers_q - rwl_pkg::ReadersW'(1);
                e_ev      = rwl_pkg::EvReleased;
                if ((readers_q == rwl_pkg::ReadersW'(1)) && (count_q != '0)) begin
                  e_last  = 1'b0;
                  state_d = StHead;
                end
              end
            end
            rwl_pkg::OpWriteUnlock: begin
              e_wr = 1'b1;
              if (!writer_q) begin
                e_ev = rwl_pkg::EvBadRelease;
              end else begin
                writer_d = 1'b0;
                e_ev     = rwl_pkg::EvReleased;
                if (count_q != '0) begin
                  e_last  = 1'b0;
                  state_d = StHead;
                end
              end
            end
          endcase
        end
      end
      StHead: begin
        // The read data holds the entry at the queue head.
        if (rd_entry.is_write) begin
          if (out_free) begin
            emit     = 1'b1;
            e_who    = rd_entry.who;
            e_ev     = rwl_pkg::EvGrantedQ;
            e_wr     = 1'b1;
            writer_d = 1'b1;
            head_d   = rwl_pkg::ptr_inc(head_q);
            count_d  = count_q - rwl_pkg::QCntW'(1);
            state_d  = StIdle;
          end
        end else begin
          cur_d   = rd_entry;
          state_d = StNext;
        end
      end
      StNext: begin
        // cur_q is the head reader; the read data holds the entry behind it,
        // which decides whether the run of readers goes on.
        if (out_free) begin
          emit      = 1'b1;
          e_who     = cur_q.who;
          e_ev      = rwl_pkg::EvGrantedQ;
          e_wr      = 1'b0;
          readers_d = readers_q + rwl_pkg::ReadersW'(1);
          head_d    = rwl_pkg::ptr_inc(head_q);
          count_d   = count_q - rwl_pkg::QCntW'(1);
          more      = (count_d != '0) && (readers_d != rwl_pkg::ReaderCap) &&
                      !rd_entry.is_write;
          e_last    = !more;
          if (more) begin
            cur_d = rd_entry;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    ram_raddr = (state_d == StNext) ? rwl_pkg::ptr_inc(head_d) : head_d;

    out_valid_d = out_valid_q;
    target_d    = target_q;
    event_d     = event_q;
    wr_d        = wr_q;
    last_d      = last_q;
    rnow_d      = rnow_q;
    wnow_d      = wnow_q;
    qnow_d      = qnow_q;
    if (emit) begin
      out_valid_d = 1'b1;
      target_d    = e_who;
      event_d     = e_ev;
      wr_d        = e_wr;
      last_d      = e_last;
      rnow_d      = readers_d;
      wnow_d      = writer_d;
      qnow_d      = rwl_pkg::WaitW'(count_d);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      readers_q   <= '0;
      writer_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      event_q     <= '0;
      wr_q        <= 1'b0;
      last_q      <= 1'b0;
      rnow_q      <= '0;
      wnow_q      <= 1'b0;
      qnow_q      <= '0;
    end else begin
      state_q     <= state_d;
      readers_q   <= readers_d;
      writer_q    <= writer_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      target_q    <= target_d;
      event_q     <= event_d;
      wr_q        <= wr_d;
      last_q      <= last_d;
      rnow_q      <= rnow_d;
      wnow_q      <= wnow_d;
      qnow_q      <= qnow_d;
    end
  end

  rwl_queue_ram #(
    .Depth (rwl_pkg::QueueDepth),
    .Width (rwl_pkg::EntryW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign target_o         = target_q;
  assign event_res_o      = event_q;
  assign grant_is_write_o = wr_q;
  assign last_o           = last_q;
  assign readers_now_o    = rnow_q;
  assign writer_now_o     = wnow_q;
  assign waiting_now_o    = qnow_q;

endmodule

// ===== sv/rwl_queue_ram.sv =====
// Wait queue storage: one write port, one read port with registered read data.
module rwl_queue_ram #(
  parameter int Depth = 16,
  parameter int Width = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
